### src/qehc_pkg.sv
// ----------------------------------------------------------------------------
// qehc_pkg
// Shared types, constants and the quadrature step decoder for the
// four-channel encoder counter and bridge speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package qehc_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int COUNT_BITS_DEF = 32;
    localparam int MAX_DUTY_DEF   = 255;

    localparam int OP_W     = 3;
    localparam int CH_W     = 2;
    localparam int REQ_W    = 16;
    localparam int POS_W    = 32;
    localparam int HELD_W   = 9;
    localparam int DUTY_W   = 8;
    localparam int STEP_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE    = 3'd0,
        OP_SET_SPEED = 3'd1,
        OP_READ      = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_CLEAR_ALL = 3'd4,
        OP_STOP_ALL  = 3'd5
    } t_op;

    typedef enum logic [STEP_W-1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } t_step;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Code is {old A, old B, new A, new B}.
    function automatic t_step decode_step(input logic [3:0] code);
        t_step step;
        unique case (code)
            4'b1101, 4'b0100, 4'b0010, 4'b1011: step = STEP_UP;
            4'b1110, 4'b0111, 4'b0001, 4'b1000: step = STEP_DOWN;
            default:                            step = STEP_NONE;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

### src/qehc_if.sv
// ----------------------------------------------------------------------------
// qehc channel interfaces
// Command channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface qehc_cmd_if
    import qehc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [CH_W-1:0]          channel;
    logic                     phase_a;
    logic                     phase_b;
    logic signed [REQ_W-1:0]  speed_request;

    modport source (output valid, operation, channel, phase_a, phase_b, speed_request,
                    input ready);
    modport sink   (input valid, operation, channel, phase_a, phase_b, speed_request,
                    output ready);
endinterface

interface qehc_res_if
    import qehc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          result_channel;
    logic signed [POS_W-1:0]  position;
    logic signed [HELD_W-1:0] held_speed;
    logic [DUTY_W-1:0]        forward_duty;
    logic [DUTY_W-1:0]        reverse_duty;
    logic [STEP_W-1:0]        step_taken;
    logic                     last;

    modport source (output valid, result_channel, position, held_speed, forward_duty,
                    reverse_duty, step_taken, last, input ready);
    modport sink   (input valid, result_channel, position, held_speed, forward_duty,
                    reverse_duty, step_taken, last, output ready);
endinterface

`default_nettype wire

### src/qehc_ram.sv
// ----------------------------------------------------------------------------
// qehc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qehc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/quad_encoder_hbridge_controller_unit.sv
// ----------------------------------------------------------------------------
// quad_encoder_hbridge_controller_unit
// Per-channel quadrature position counter and signed bridge speed store,
// kept in one RAM entry per channel and updated read-modify-write.
// ----------------------------------------------------------------------------
//  Port     | Dir | Carries
//  ---------+-----+---------------------------------------------------------
//  i_cmd    | in  | operation, channel, phase_a, phase_b, speed_request
//  o_res    | out | result_channel, position, held_speed, duties, step, last
//
// An addressed operation first reads the channel entry from RAM, then
// updates it, writes it back for sample and set-speed, and loads the result
// register. Stop-all reads channel 0 when accepted, then loads one result
// per channel, reading the next channel each time until the last.
// Unused operation codes and out-of-range channels are accepted and dropped.
// Reset marks every entry as zero through per-entry flags; no clearing pass.
// The update waits while the result register holds an untaken transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_encoder_hbridge_controller_unit
    import qehc_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int MAX_DUTY   = MAX_DUTY_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qehc_cmd_if.sink   i_cmd,
    qehc_res_if.source o_res
);

    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SPEED_W = $clog2(MAX_DUTY + 1) + 1;
    localparam int ENT_W   = COUNT_BITS + 2 + SPEED_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
    localparam int signed MAXD = MAX_DUTY;

    // Control state
    t_state              r_state, n_state;
    t_op                 r_op;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [1:0]          r_phase_new;
    logic signed [REQ_W-1:0] r_req;

    // Per-entry zero flags: a set flag overrides the field stored in RAM.
    logic [CHANNELS-1:0] r_cnt_clr;
    logic [CHANNELS-1:0] r_ph_clr;
    logic [CHANNELS-1:0] r_spd_clr;

    // Result register
    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out_ch;
    logic signed [POS_W-1:0]  r_out_pos;
    logic signed [HELD_W-1:0] r_out_held;
    logic [DUTY_W-1:0]        r_out_fwd;
    logic [DUTY_W-1:0]        r_out_rev;
    logic [STEP_W-1:0]        r_out_step;
    logic                     r_out_last;

    // RAM port
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_wdata, ram_rdata;

    // Decoded command
    t_op              in_op;
    logic             in_fire;
    logic             in_ch_ok;
    logic [IDX_W-1:0] in_idx;

    // Update datapath
    logic [COUNT_BITS-1:0]     cur_cnt, new_cnt;
    logic [1:0]                cur_ph, new_ph;
    logic signed [SPEED_W-1:0] cur_spd, new_spd, clamp_spd;
    t_step                     step;
    logic signed [31:0]        req32, spd32, fwd32, rev32;
    logic [63:0]               cnt64;
    logic [31:0]               idx32;

    logic out_free, load_out;
    logic set_cnt_clr_all, set_spd_clr_all, set_cnt_clr_one, clr_flags_one;

    assign in_op    = t_op'(i_cmd.operation);
    assign in_fire  = i_cmd.valid && i_cmd.ready;
    assign in_ch_ok = {30'd0, i_cmd.channel} < 32'(CHANNELS);
    assign in_idx   = IDX_W'(i_cmd.channel);
    assign i_cmd.ready = (r_state == ST_IDLE);

    assign out_free = !r_out_valid || o_res.ready;

    qehc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CHANNELS),
        .AW    (IDX_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Effective entry contents after the zero flags.
    always_comb begin
        cur_cnt = r_cnt_clr[r_idx] ? '0 : ram_rdata[ENT_W-1 -: COUNT_BITS];
        cur_ph  = r_ph_clr[r_idx]  ? '0 : ram_rdata[SPEED_W +: 2];
        cur_spd = r_spd_clr[r_idx] ? '0 : $signed(ram_rdata[SPEED_W-1:0]);
    end

    always_comb begin
        req32 = 32'(r_req);
        if (req32 > MAXD) begin
            clamp_spd = SPEED_W'(MAXD);
        end else if (req32 < -MAXD) begin
            clamp_spd = SPEED_W'(-MAXD);
        end else begin
            clamp_spd = SPEED_W'(req32);
        end
    end

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        ram_re          = 1'b0;
        ram_raddr       = in_idx;
        ram_we          = 1'b0;
        load_out        = 1'b0;
        set_cnt_clr_all = 1'b0;
        set_spd_clr_all = 1'b0;
        set_cnt_clr_one = 1'b0;
        clr_flags_one   = 1'b0;
        new_cnt         = cur_cnt;
        new_ph          = cur_ph;
        new_spd         = cur_spd;
        step            = STEP_NONE;

        // The datapath values are evaluated every cycle; writes are gated below.
        unique case (r_op)
            OP_SAMPLE: begin
                step   = decode_step({cur_ph, r_phase_new});
                new_ph = r_phase_new;
                if (step == STEP_UP) begin
                    new_cnt = cur_cnt + COUNT_BITS'(1);
                end else if (step == STEP_DOWN) begin
                    new_cnt = cur_cnt - COUNT_BITS'(1);
                end
            end
            OP_SET_SPEED: new_spd = clamp_spd;
            OP_CLEAR:     new_cnt = '0;
            OP_CLEAR_ALL: new_cnt = '0;
            OP_STOP_ALL:  new_spd = '0;
            default: ;
        endcase

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_STOP_ALL) begin
                        set_spd_clr_all = 1'b1;
                        ram_re          = 1'b1;
                        ram_raddr       = '0;
                        n_idx           = '0;
                        n_state         = ST_EXEC;
                    end else if (i_cmd.operation < OP_STOP_ALL && in_ch_ok) begin
                        ram_re  = 1'b1;
                        n_idx   = in_idx;
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    load_out = 1'b1;
                    unique case (r_op)
                        OP_SAMPLE, OP_SET_SPEED: begin
                            ram_we        = 1'b1;
                            clr_flags_one = 1'b1;
                        end
                        OP_CLEAR:     set_cnt_clr_one = 1'b1;
                        OP_CLEAR_ALL: set_cnt_clr_all = 1'b1;
                        default: ;
                    endcase
                    if (r_op == OP_STOP_ALL && r_idx != LAST_IDX) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + IDX_W'(1);
                        n_idx     = r_idx + IDX_W'(1);
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign ram_wdata = {new_cnt, new_ph, new_spd};

    // Result fields
    always_comb begin
        spd32 = 32'(new_spd);
        fwd32 = (spd32 > 0) ? spd32 : 32'sd0;
        rev32 = (spd32 < 0) ? -spd32 : 32'sd0;
        cnt64 = 64'(new_cnt);
        idx32 = 32'(r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_READ;
            r_idx       <= '0;
            r_cnt_clr   <= '1;
            r_ph_clr    <= '1;
            r_spd_clr   <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (in_fire) begin
                r_op <= in_op;
            end
            if (set_spd_clr_all) begin
                r_spd_clr <= '1;
            end
            if (set_cnt_clr_all) begin
                r_cnt_clr <= '1;
            end
            if (set_cnt_clr_one) begin
                r_cnt_clr[r_idx] <= 1'b1;
            end
            if (clr_flags_one) begin
                r_cnt_clr[r_idx] <= 1'b0;
                r_ph_clr[r_idx]  <= 1'b0;
                r_spd_clr[r_idx] <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_phase_new <= {i_cmd.phase_a, i_cmd.phase_b};
            r_req       <= i_cmd.speed_request;
        end
        if (load_out) begin
            r_out_ch   <= idx32[CH_W-1:0];
            r_out_pos  <= cnt64[POS_W-1:0];
            r_out_held <= spd32[HELD_W-1:0];
            r_out_fwd  <= fwd32[DUTY_W-1:0];
            r_out_rev  <= rev32[DUTY_W-1:0];
            r_out_step <= step;
            r_out_last <= (r_op != OP_STOP_ALL) || (r_idx == LAST_IDX);
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.result_channel = r_out_ch;
    assign o_res.position       = r_out_pos;
    assign o_res.held_speed     = r_out_held;
    assign o_res.forward_duty   = r_out_fwd;
    assign o_res.reverse_duty   = r_out_rev;
    assign o_res.step_taken     = r_out_step;
    assign o_res.last           = r_out_last;

endmodule

`default_nettype wire
